@@ hw/rtl/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
`default_nettype none

package ple_pkg;

    localparam int PLE_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int CMD_W        = 2;
    localparam int COUNT_W      = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_APPEND  = 2'd2,
        CMD_REMOVE  = 2'd3
    } ple_cmd_e;

    // Operation broadcast along the cell row for one accepted beat.
    typedef struct packed {
        logic ins;
        logic ext;
    } ple_op_t;

endpackage

`default_nettype wire

@@ hw/rtl/ple_cell.sv @@
// One list cell: holds an element and shifts with its neighbours.
`default_nettype none

module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic              clk,
    input  wire ple_op_t           op,
    input  wire logic [CW-1:0]     pos,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic [DATA_W-1:0] left,
    input  wire logic [DATA_W-1:0] right,
    output logic      [DATA_W-1:0] data,
    output logic      [DATA_W-1:0] rd
);

    localparam logic [CW-1:0] ME = CW'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (op.ins)
        begin
            // cells above the slot take their lower neighbour, the slot takes the value
            if (pos < ME)
            begin
                data_next = left;
            end
            else if (pos == ME)
            begin
                data_next = value;
            end
        end
        else if (op.ext)
        begin
            if (pos <= ME)
            begin
                data_next = right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign rd   = (pos == ME) ? data_reg : '0;

endmodule

`default_nettype wire

@@ hw/rtl/positional_list_engine.sv @@
// Top level of the positional list engine: control, cell row and result register.
// A bounded ordered list of signed 32-bit elements kept in a row of CAPACITY
// cells, one element per cell. Every cell shifts up, shifts down or holds in
// the same clock edge, so each command (insert at position, extract at
// position, append, remove from end) acts on the row at once and a new beat
// may be accepted every cycle; the result appears in an output register in
// the cycle after acceptance, and input is stalled only while that register
// holds a beat that the sink is stalling. The extracted element is picked
// by a one-hot select across the row, which sets the longest path. Cell
// contents are not reset; only positions below the count are ever read.
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = PLE_CAPACITY
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [CMD_W-1:0]         cmd,
    input  wire logic [POS_W-1:0]         position,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      removed_value,
    output logic                          error,
    output logic [COUNT_W-1:0]            count,
    output logic                          empty_res
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int OCW  = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [CMPW-1:0] CAP_X = CMPW'(CAPACITY);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  removed_reg;
    logic               error_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic               empty_reg;

    logic               accept;
    logic               ok;
    ple_op_t            op;
    logic [CW-1:0]      epos;
    logic [CMPW-1:0]    pos_x;
    logic [CMPW-1:0]    cnt_x;
    logic [OCW-1:0]     cnt_o;
    logic [DATA_W-1:0]  rd_sel;

    logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
    logic [CAPACITY-1:0][DATA_W-1:0] cell_rd;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign pos_x    = CMPW'(position);
    assign cnt_x    = CMPW'(count_reg);

    always_comb
    begin
        ok   = 1'b0;
        epos = pos_x[CW-1:0];
        case (ple_cmd_e'(cmd))
            CMD_INSERT:
            begin
                ok = (cnt_x < CAP_X) && (pos_x <= cnt_x);
            end
            CMD_EXTRACT:
            begin
                ok = (pos_x < cnt_x);
            end
            CMD_APPEND:
            begin
                ok   = (cnt_x < CAP_X);
                epos = count_reg;
            end
            CMD_REMOVE:
            begin
                ok   = (count_reg != '0);
                epos = count_reg - CW'(1);
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // cmd bit 0 marks the taking commands, bit 0 clear the putting ones
    assign op.ins = accept && ok && !cmd[0];
    assign op.ext = accept && ok && cmd[0];

    always_comb
    begin
        count_next = count_reg;
        if (op.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.ext)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_w;
            logic [DATA_W-1:0] right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = value;
            end
            else
            begin : g_mid_l
                assign left_w = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_w = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_w = cell_data[gi+1];
            end

            ple_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .clk   (clk),
                .op    (op),
                .pos   (epos),
                .value (value),
                .left  (left_w),
                .right (right_w),
                .data  (cell_data[gi]),
                .rd    (cell_rd[gi])
            );
        end
    endgenerate

    // at most one cell drives a non-zero select term
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_sel = rd_sel | cell_rd[i];
        end
    end

    assign cnt_o = OCW'(count_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg   <= op.ext ? rd_sel : '0;
            error_reg     <= !ok;
            count_out_reg <= cnt_o[COUNT_W-1:0];
            empty_reg     <= (count_next == '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign error         = error_reg;
    assign count         = count_out_reg;
    assign empty_res     = empty_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= CAP_X)
        else $error("element count above capacity");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with empty result register");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        op.ins |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_no_op_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !ok) |=> (count_reg == $past(count_reg)) && error_reg)
        else $error("refused command changed the list");

endmodule

`default_nettype wire
